// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Both macros clock on i_clk; the first one is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KFPI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("kfpi check failed");

`define KFPI_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("kfpi reset check failed");

`endif

// ===== rtl/core/kfpi_pkg.sv =====
package kfpi_pkg;

    localparam int TIME_W         = 32;
    localparam int POS_W          = 32;
    localparam int COORDS         = 3;
    localparam int FRAC_W         = 16;
    // The blend factor is Q0.16 with 65536 meaning exactly one, so it needs 17 bits.
    localparam int F_W            = FRAC_W + 1;
    localparam int DIV_STEPS      = F_W;
    localparam int CNT_W          = 7;
    localparam int IDX_W          = 6;
    localparam int IN_TDATA_W     = 168;
    localparam int OUT_TDATA_W    = COORDS * POS_W;
    localparam int DEF_MAX_FRAMES = 64;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [COORDS-1:0][POS_W-1:0] t_pos;

    typedef struct packed {
        logic           done;
        logic [F_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic done;
    } t_blend_rsp;

endpackage

// ===== rtl/core/kfpi_table.sv =====
module kfpi_table #(
    parameter int DEPTH = kfpi_pkg::DEF_MAX_FRAMES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [kfpi_pkg::TIME_W-1:0] i_wr_time,
    input  kfpi_pkg::t_pos              i_wr_pos,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [kfpi_pkg::TIME_W-1:0] o_rd_time,
    output kfpi_pkg::t_pos              o_rd_pos
);

    logic [kfpi_pkg::TIME_W-1:0] mem_time [DEPTH];
    kfpi_pkg::t_pos              mem_pos  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_time[i_wr_addr] <= i_wr_time;
            mem_pos[i_wr_addr]  <= i_wr_pos;
        end
    end

    // Registered read: data shows in the cycle after the address.
    always_ff @(posedge i_clk) begin
        o_rd_time <= mem_time[i_rd_addr];
        o_rd_pos  <= mem_pos[i_rd_addr];
    end

endmodule

// ===== rtl/core/kfpi_div.sv =====
module kfpi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kfpi_pkg::TIME_W-1:0] i_diff,
    input  logic [kfpi_pkg::TIME_W-1:0] i_den,
    output kfpi_pkg::t_div_rsp          o_rsp
);

    localparam int SW = $clog2(kfpi_pkg::DIV_STEPS);

    logic [kfpi_pkg::TIME_W-1:0] r_rem;
    logic [kfpi_pkg::TIME_W-1:0] r_den;
    logic [kfpi_pkg::F_W-1:0]    r_quo;
    logic [SW-1:0]               r_cnt;
    logic                        r_lsb;
    logic                        r_busy;
    logic                        r_done;

    logic                      in_bit;
    logic [kfpi_pkg::TIME_W:0] trial;
    logic [kfpi_pkg::TIME_W:0] diff_sub;
    logic                      ge;

    // Restoring division of (diff << 16) by den. The quotient never exceeds
    // 65536 because diff <= den, so the top of the dividend starts below den.
    assign in_bit   = (r_cnt == '0) ? r_lsb : 1'b0;
    assign trial    = {r_rem, in_bit};
    assign diff_sub = trial - {1'b0, r_den};
    assign ge       = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == SW'(kfpi_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_diff[kfpi_pkg::TIME_W-1:1]};
            r_lsb <= i_diff[0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff_sub[kfpi_pkg::TIME_W-1:0] : trial[kfpi_pkg::TIME_W-1:0];
            r_quo <= {r_quo[kfpi_pkg::F_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== rtl/core/kfpi_blend.sv =====
module kfpi_blend (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [kfpi_pkg::F_W-1:0] i_f,
    input  kfpi_pkg::t_pos           i_p0,
    input  kfpi_pkg::t_pos           i_p1,
    output kfpi_pkg::t_blend_rsp     o_rsp,
    output kfpi_pkg::t_pos           o_pos
);

    localparam int DW = kfpi_pkg::POS_W + 1;
    localparam int PW = DW + kfpi_pkg::F_W + 1;

    typedef enum logic [2:0] {
        PH_DIFF = 3'b001,
        PH_MUL  = 3'b010,
        PH_ADD  = 3'b100
    } t_phase;

    t_phase               r_ph;
    logic [1:0]           r_k;
    logic                 r_busy;
    logic                 r_done;
    logic signed [DW-1:0] r_d;
    logic signed [PW-1:0] r_prod;
    kfpi_pkg::t_pos       r_pos;

    logic signed [DW-1:0] p0k;
    logic signed [DW-1:0] p1k;

    assign p0k = {i_p0[r_k][kfpi_pkg::POS_W-1], i_p0[r_k]};
    assign p1k = {i_p1[r_k][kfpi_pkg::POS_W-1], i_p1[r_k]};

    // One coordinate at a time through subtract, multiply and add stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
            r_ph   <= PH_DIFF;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
                r_ph   <= PH_DIFF;
            end else if (r_busy) begin
                case (r_ph)
                    PH_DIFF: r_ph <= PH_MUL;
                    PH_MUL:  r_ph <= PH_ADD;
                    PH_ADD: begin
                        r_ph <= PH_DIFF;
                        if (r_k == 2'(kfpi_pkg::COORDS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                    default: r_ph <= PH_DIFF;
                endcase
            end
        end
    end

    // The floor of prod / 65536 is an arithmetic shift; only its low 32 bits count.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            case (r_ph)
                PH_DIFF: r_d    <= p1k - p0k;
                PH_MUL:  r_prod <= r_d * $signed({1'b0, i_f});
                PH_ADD:  r_pos[r_k] <= i_p0[r_k]
                             + r_prod[kfpi_pkg::FRAC_W +: kfpi_pkg::POS_W];
                default: r_d    <= r_d;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_pos      = r_pos;

endmodule

// ===== rtl/core/keyframe_position_interpolator.sv =====
// Keyframe position interpolator. The block keeps a table of up to MAX_FRAMES
// keyframes, each a time (unsigned Q16.16) and an xyz position (signed Q16.16),
// meant to be sorted by ascending time. An input beat with tuser low writes one
// keyframe into slot frame_index and gives no result; a slot at or beyond
// MAX_FRAMES is ignored. An input beat with tuser high is a query: the block
// scans the first frame_count entries for the first time at or after
// query_time and blends linearly between that keyframe and the one before it,
// with a Q0.16 factor ((q - t0) << 16) / (t1 - t0) truncated. A query at or
// before the first keyframe returns the first position, one past the last
// keyframe returns the last position, and an empty table returns found low
// with zero data. The table contents are undefined until written, so every
// slot below frame_count must be loaded before a query. A write beat leaves the
// block ready for the next beat. For a query the scan reads one entry a cycle
// from the single read port of the table, then a 17-step restoring divider
// forms the factor and one shared multiplier blends the three coordinates one
// after another. The input side is not ready while a query is in progress; a
// finished result waits in the output register, and the next beat is taken
// meanwhile. Write frame_count only while the block is idle; a value above
// MAX_FRAMES acts as MAX_FRAMES.
module keyframe_position_interpolator #(
    parameter int MAX_FRAMES = kfpi_pkg::DEF_MAX_FRAMES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata from bit 0: frame_index[5:0], key_time[31:0], key_x[31:0],
    // key_y[31:0], key_z[31:0], query_time[31:0], two zero pad bits.
    input  logic [kfpi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser bit 0: action (0 write keyframe, 1 query).
    input  logic                             s_axis_tuser,
    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata from bit 0: out_x[31:0], out_y[31:0], out_z[31:0].
    output logic [kfpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser bit 0: found.
    output logic                             m_axis_tuser,
    // Configuration: frame_count.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kfpi_pkg::CNT_W-1:0]       i_cfg_data
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int NW = (CW > kfpi_pkg::CNT_W) ? CW : kfpi_pkg::CNT_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,
        S_FPREV = 10'b0000000100,
        S_FHIT  = 10'b0000001000,
        S_FLAT  = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_BLEND = 10'b0001000000,
        S_SEL0  = 10'b0010000000,
        S_SEL1  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [kfpi_pkg::CNT_W-1:0]  r_count;
    logic [kfpi_pkg::TIME_W-1:0] r_q;
    logic [kfpi_pkg::TIME_W-1:0] r_t0;
    logic [kfpi_pkg::TIME_W-1:0] r_t1;
    kfpi_pkg::t_pos              r_p0;
    kfpi_pkg::t_pos              r_p1;
    kfpi_pkg::t_pos              r_res;
    logic                        r_found;
    logic [CW-1:0]               r_idx;
    logic [CW-1:0]               r_pidx;
    logic                        r_pend;
    logic [AW-1:0]               r_hit;
    logic [AW-1:0]               r_sel;
    logic                        r_out_valid;
    logic                        r_out_found;
    kfpi_pkg::t_pos              r_out_pos;

    // Input fields.
    logic [kfpi_pkg::IDX_W-1:0]  in_index;
    logic [kfpi_pkg::TIME_W-1:0] in_key_time;
    kfpi_pkg::t_pos              in_key_pos;
    logic [kfpi_pkg::TIME_W-1:0] in_query_time;

    assign in_index      = s_axis_tdata[5:0];
    assign in_key_time   = s_axis_tdata[37:6];
    assign in_key_pos    = kfpi_pkg::t_pos'(s_axis_tdata[133:38]);
    assign in_query_time = s_axis_tdata[165:134];

    logic                        s_fire;
    logic                        wr_en;
    logic [AW-1:0]               rd_addr;
    logic [kfpi_pkg::TIME_W-1:0] rd_time;
    kfpi_pkg::t_pos              rd_pos;
    logic [NW-1:0]               cnt_ext;
    logic [CW-1:0]               n_valid;
    logic [CW-1:0]               n_last;
    logic                        hit_now;
    logic                        out_load;
    kfpi_pkg::t_div_rsp          div_rsp;
    kfpi_pkg::t_blend_rsp        blend_rsp;
    kfpi_pkg::t_pos              blend_pos;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Number of valid keyframes, limited to the table depth.
    assign cnt_ext = NW'(r_count);
    assign n_valid = (cnt_ext > NW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(cnt_ext);
    assign n_last  = n_valid - CW'(1);

    assign wr_en = s_fire && (s_axis_tuser == kfpi_pkg::ACT_WRITE)
                   && (32'(in_index) < 32'(MAX_FRAMES));

    // The table address comes from whichever step of the search is running.
    always_comb begin
        case (r_state)
            S_FPREV: rd_addr = r_hit - AW'(1);
            S_FHIT:  rd_addr = r_hit;
            S_SEL0:  rd_addr = r_sel;
            default: rd_addr = r_idx[AW-1:0];
        endcase
    end

    kfpi_table #(
        .DEPTH(MAX_FRAMES),
        .AW   (AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(AW'(in_index)),
        .i_wr_time(in_key_time),
        .i_wr_pos (in_key_pos),
        .i_rd_addr(rd_addr),
        .o_rd_time(rd_time),
        .o_rd_pos (rd_pos)
    );

    // The keyframe before the match always lies below the query, so the
    // divisor is never zero and the quotient stays within one.
    kfpi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_FLAT),
        .i_diff (r_q - r_t0),
        .i_den  (r_t1 - r_t0),
        .o_rsp  (div_rsp)
    );

    kfpi_blend u_blend (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start((r_state == S_DIV) && div_rsp.done),
        .i_f    (div_rsp.quo),
        .i_p0   (r_p0),
        .i_p1   (r_p1),
        .o_rsp  (blend_rsp),
        .o_pos  (blend_pos)
    );

    // During the scan the table data comes from a registered read, so the
    // compare works on the entry issued the cycle before.
    assign hit_now  = r_pend && (rd_time >= r_q);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_fire && (s_axis_tuser == kfpi_pkg::ACT_QUERY)) begin
                    n_state = (n_valid == '0) ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit_now) begin
                    n_state = (r_pidx == '0) ? S_SEL0 : S_FPREV;
                end else if (r_pend && (r_pidx == n_last)) begin
                    n_state = S_SEL0;
                end
            end
            S_FPREV: n_state = S_FHIT;
            S_FHIT:  n_state = S_FLAT;
            S_FLAT:  n_state = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                if (blend_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_SEL0: n_state = S_SEL1;
            S_SEL1: n_state = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_pend <= (r_idx < n_valid);
                if (r_idx < n_valid) begin
                    r_idx <= r_idx + CW'(1);
                end
            end else begin
                r_pend <= 1'b0;
                r_idx  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
        case (r_state)
            S_IDLE: begin
                r_q     <= in_query_time;
                r_res   <= '0;
                r_found <= 1'b0;
            end
            S_SCAN: begin
                if (hit_now) begin
                    r_t1  <= rd_time;
                    r_hit <= r_pidx[AW-1:0];
                    r_sel <= '0;
                end else begin
                    r_sel <= n_last[AW-1:0];
                end
            end
            S_FHIT: begin
                r_t0 <= rd_time;
                r_p0 <= rd_pos;
            end
            S_FLAT: r_p1 <= rd_pos;
            S_BLEND: begin
                r_res   <= blend_pos;
                r_found <= 1'b1;
            end
            S_SEL1: begin
                r_res   <= rd_pos;
                r_found <= 1'b1;
            end
            default: r_q <= r_q;
        endcase
        if (out_load) begin
            r_out_pos   <= r_res;
            r_out_found <= r_found;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pos;
    assign m_axis_tuser  = r_out_found;

endmodule

// ===== rtl/core/kfpi_checker.sv =====
`include "assert_macros.svh"

module kfpi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [kfpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // A result beat stays offered until it is taken.
    `KFPI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

    // A query keeps the input side busy for at least the next cycle.
    `KFPI_ASSERT(a_query_busy, s_fire && (s_axis_tuser == kfpi_pkg::ACT_QUERY) |=> !s_axis_tready)

    // A keyframe write finishes in its own cycle and leaves the block ready.
    `KFPI_ASSERT(a_write_ready, s_fire && (s_axis_tuser == kfpi_pkg::ACT_WRITE) |=> s_axis_tready)

    // An empty table reports all-zero coordinates.
    `KFPI_ASSERT(a_empty_zero, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))

    // Reset leaves no result pending.
    `KFPI_ASSERT_RST(a_reset_clear, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind keyframe_position_interpolator kfpi_checker u_kfpi_checker (.*);

// ===== verif/keyframe_position_interpolator_tb.sv =====
module keyframe_position_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAMES  = kfpi_pkg::DEF_MAX_FRAMES;
    localparam int IN_TDATA_W  = kfpi_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = kfpi_pkg::OUT_TDATA_W;
    localparam int CNT_W       = kfpi_pkg::CNT_W;

    // One input beat as it travels: the action rides in tuser, and the rest is the
    // tdata layout from bit 0 upward (slot, key time, key x/y/z, query time, pad).
    typedef struct packed {
        logic        act;
        logic [1:0]  pad;
        logic [31:0] query_time;
        logic [31:0] key_z;
        logic [31:0] key_y;
        logic [31:0] key_x;
        logic [31:0] key_time;
        logic [5:0]  slot;
    } t_kf_beat;

    // One result beat: found rides in tuser, x sits in the low tdata bits.
    typedef struct packed {
        logic        found;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_kf_point;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data = '0;

    keyframe_position_interpolator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Beats waiting to be offered, and the interpolated points owed by the block
    // for queries it has already accepted, oldest first.
    t_kf_beat  beats_to_send[$];
    t_kf_point points_due[$];

    // Our own copy of the keyframe table and of the frame count register, updated
    // in step with the beats and register writes that the block accepts.
    logic [31:0]      key_time_tbl[MAX_FRAMES];
    logic [31:0]      key_pos_tbl[MAX_FRAMES][3];
    logic [CNT_W-1:0] frame_count_model = '0;

    // The stimulus side keeps a separate view of the table times, as queued, so it
    // can aim query times at the interesting spots between keyframes.
    logic [31:0] gen_time[MAX_FRAMES];
    int          gen_n = 0;
    int          items_queued = 0;

    int  mismatches = 0;
    int  results_seen = 0;
    int  cfg_beats = 0;
    bit  beat_taken = 1'b0;
    bit  hold_rx = 1'b0;
    int  burst_left = 1;
    int  gap_left = 0;
    int  rx_cycle = 0;
    int  rx_mode = 0;

    initial begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            key_time_tbl[i] = '0;
            gen_time[i] = '0;
            for (int k = 0; k < 3; k++) key_pos_tbl[i][k] = '0;
        end
    end

    // One coordinate: p0 + floor((p1 - p0) * f / 65536), wrapped to 32 bits. The
    // difference needs 33 bits and the product 50, so a 64-bit signed value holds
    // it, and an arithmetic shift gives the floor for negative products.
    function automatic logic [31:0] blend_coord(input logic [31:0] p0, input logic [31:0] p1,
                                                input longint fac);
        longint diff;
        diff = longint'($signed(p1)) - longint'($signed(p0));
        return 32'(longint'($signed(p0)) + ((diff * fac) >>> 16));
    endfunction

    // Position at time q from the current table and frame count.
    function automatic t_kf_point interpolate_at(input logic [31:0] q);
        t_kf_point   pt;
        int          n;
        int          hit;
        int          idx;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] span;
        logic [63:0] num;
        logic [63:0] fac;
        pt = '0;
        // A count above the table size acts as a full table.
        n = (frame_count_model > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count_model);
        if (n == 0) return pt;
        pt.found = 1'b1;
        // First keyframe at or after q; n means the query lies past the last one.
        hit = n;
        for (int i = n - 1; i >= 0; i--) begin
            if (key_time_tbl[i] >= q) hit = i;
        end
        if (hit == 0 || hit == n) begin
            idx = (hit == 0) ? 0 : n - 1;
            pt.x = key_pos_tbl[idx][0];
            pt.y = key_pos_tbl[idx][1];
            pt.z = key_pos_tbl[idx][2];
        end else begin
            // The previous keyframe always lies below q, so the divisor is never zero,
            // even when the table is not sorted.
            t0 = key_time_tbl[hit - 1];
            t1 = key_time_tbl[hit];
            span = q - t0;
            num = {16'b0, span, 16'b0};
            fac = num / {32'b0, t1 - t0};
            if (fac > 64'd65536) fac = 64'd65536;
            pt.x = blend_coord(key_pos_tbl[hit - 1][0], key_pos_tbl[hit][0], longint'(fac));
            pt.y = blend_coord(key_pos_tbl[hit - 1][1], key_pos_tbl[hit][1], longint'(fac));
            pt.z = blend_coord(key_pos_tbl[hit - 1][2], key_pos_tbl[hit][2], longint'(fac));
        end
        return pt;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Everything the block accepts is observed here at the rising edge: register
    // writes and keyframe writes update our copy of the state, queries push the
    // point they should produce, and each result beat is checked field by field
    // against the oldest point owed.
    always @(posedge i_clk) begin
        t_kf_beat  b;
        t_kf_point got;
        t_kf_point want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                frame_count_model = i_cfg_data;
                cfg_beats++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                b = t_kf_beat'({s_axis_tuser, s_axis_tdata});
                beat_taken = 1'b1;
                if (b.act == kfpi_pkg::ACT_WRITE) begin
                    // The 6-bit slot always falls inside the 64-entry table.
                    key_time_tbl[b.slot] = b.key_time;
                    key_pos_tbl[b.slot][0] = b.key_x;
                    key_pos_tbl[b.slot][1] = b.key_y;
                    key_pos_tbl[b.slot][2] = b.key_z;
                end else begin
                    points_due.push_back(interpolate_at(b.query_time));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_kf_point'({m_axis_tuser, m_axis_tdata});
                results_seen++;
                if (points_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result beat with no query outstanding: %h",
                                 $realtime, got);
                    end
                end else begin
                    want = points_due.pop_front();
                    if (got.found !== want.found) flag_mismatch("found", want.found, got.found);
                    if (got.x !== want.x) flag_mismatch("out_x", want.x, got.x);
                    if (got.y !== want.y) flag_mismatch("out_y", want.y, got.y);
                    if (got.z !== want.z) flag_mismatch("out_z", want.z, got.z);
                end
            end
        end
    end

    // Sender: offers beats in bursts of random length separated by random gaps.
    // About a quarter of the gaps are zero, so some stretches run back to back.
    // A beat stays on the bus until it is taken; a new one can follow on the very
    // next cycle without tvalid dropping in between.
    always @(negedge i_clk) begin
        logic     nxt_valid;
        t_kf_beat nb;
        nxt_valid = s_axis_tvalid && !beat_taken;
        beat_taken = 1'b0;
        if (i_rst_n && !nxt_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (beats_to_send.size() > 0) begin
                nb = beats_to_send.pop_front();
                s_axis_tdata <= nb[IN_TDATA_W-1:0];
                s_axis_tuser <= nb.act;
                nxt_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
    end

    // Receiver: switches its mode between always ready, coin-flip stalls,
    // ready one cycle in four, and rare stalls. The long hold-off below overrides it.
    always @(negedge i_clk) begin
        logic rx_ok;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        rx_cycle++;
        case (rx_mode)
            0: rx_ok = 1'b1;
            1: rx_ok = 1'($urandom_range(0, 1));
            2: rx_ok = (rx_cycle % 4 == 0);
            default: rx_ok = ($urandom_range(0, 9) != 0);
        endcase
        m_axis_tready <= rx_ok && !hold_rx;
    end

    // Once a hundred results have come out, the receiver holds off while the
    // sender keeps offering, so the result register fills and the block has to
    // stall its input.
    initial begin
        while (results_seen < 100) @(negedge i_clk);
        hold_rx <= 1'b1;
        repeat (500) @(negedge i_clk);
        hold_rx <= 1'b0;
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_write(input logic [5:0] slot, input logic [31:0] t,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        t_kf_beat b;
        b.act = kfpi_pkg::ACT_WRITE;
        b.pad = '0;
        b.slot = slot;
        b.key_time = t;
        b.key_x = x;
        b.key_y = y;
        b.key_z = z;
        // The block ignores the query time on a write, so it carries noise.
        b.query_time = $urandom();
        beats_to_send.push_back(b);
        gen_time[slot] = t;
        items_queued++;
    endtask

    task automatic queue_query(input logic [31:0] q);
        t_kf_beat b;
        b.act = kfpi_pkg::ACT_QUERY;
        b.pad = '0;
        // Slot and key fields are ignored on a query and carry noise.
        b.slot = 6'($urandom());
        b.key_time = $urandom();
        b.key_x = $urandom();
        b.key_y = $urandom();
        b.key_z = $urandom();
        b.query_time = q;
        beats_to_send.push_back(b);
        items_queued++;
    endtask

    // Loads slots 0..n-1. A sorted table uses either tight steps, which keep the
    // times close, or wide steps that spread the keyframes over the whole time
    // range, and now and then repeats a time. A scrambled table has random times.
    task automatic load_table(input int n, input bit scrambled);
        logic [31:0] t;
        logic [31:0] step_max;
        t = ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom_range(0, 32'h0010_0000));
        step_max = ($urandom_range(0, 2) == 0) ? 32'h0003_0000 : 32'hFFE0_0000 / (n + 1);
        for (int i = 0; i < n; i++) begin
            if (scrambled) t = $urandom();
            queue_write(6'(i), t, rand_coord(), rand_coord(), rand_coord());
            if (!scrambled && $urandom_range(0, 15) != 0) t += $urandom_range(1, step_max);
        end
    endtask

    // Query times aimed at the table: at or just before the first keyframe, exactly on one,
    // just after one, between two, past the last, the range ends, or random.
    function automatic logic [31:0] pick_query_time();
        int          i;
        logic [31:0] lo;
        logic [31:0] hi;
        if (gen_n == 0) return $urandom();
        i = $urandom_range(0, gen_n - 1);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return gen_time[0] - $urandom_range(0, 3);
            2: return gen_time[i];
            3: return gen_time[i] + 1;
            4: return gen_time[gen_n - 1] + $urandom_range(1, 16);
            5: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: begin
                if (i == 0) return gen_time[0];
                lo = gen_time[i - 1];
                hi = gen_time[i];
                return (hi > lo) ? lo + $urandom_range(1, hi - lo) : hi;
            end
        endcase
    endfunction

    // Waits until every queued beat is taken and every owed result has come out,
    // then lets a full query latency pass, since a trailing write gives no result.
    task automatic wait_idle();
        while (beats_to_send.size() != 0 || s_axis_tvalid || points_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (150) @(negedge i_clk);
    endtask

    // Frame count writes happen only with the block idle.
    task automatic set_frame_count(input logic [CNT_W-1:0] value);
        int start;
        start = cfg_beats;
        @(negedge i_clk);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        while (cfg_beats == start) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        gen_n = (value > MAX_FRAMES) ? MAX_FRAMES : int'(value);
    endtask

    initial begin
        int          phase;
        int          cnt;
        int          mix;
        int          slot;
        logic [31:0] t;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table after reset: queries answer with found low and zero data.
        queue_query(32'h0);
        queue_query(32'hFFFF_FFFF);

        // Three keyframes at 1.0, 3.0 and 3.0 seconds, with full-scale swings
        // between the first two, plus the top slot written with the largest time.
        queue_write(6'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_write(6'd1, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_write(6'd2, 32'h0003_0000, 32'h0001_8000, 32'hFFFF_0000, 32'h1234_5678);
        queue_write(6'd63, 32'hFFFF_FFFF, rand_coord(), rand_coord(), rand_coord());
        wait_idle();
        set_frame_count(CNT_W'(3));

        // Before the first keyframe, on it, just after it, halfway, just before the
        // second, exactly on the second (factor of one), past the last, and the top.
        queue_query(32'h0);
        queue_query(32'h0001_0000);
        queue_query(32'h0001_0001);
        queue_query(32'h0002_0000);
        queue_query(32'h0002_FFFF);
        queue_query(32'h0003_0000);
        queue_query(32'h0003_0001);
        queue_query(32'hFFFF_FFFF);
        wait_idle();

        // A single keyframe answers every query with its own position.
        set_frame_count(CNT_W'(1));
        queue_query(32'h0);
        queue_query(32'h0002_0000);
        queue_query(32'hFFFF_FFFF);

        // Random phases: each sets a frame count, loads that many keyframes up to the
        // table size (mostly sorted, sometimes scrambled) and then runs a mix of aimed
        // queries and keyframe rewrites. The counts cycle through the extremes,
        // including a value above the table size and an empty table.
        phase = 0;
        while (items_queued < 1100) begin
            case (phase % 8)
                0: cnt = MAX_FRAMES;
                1: cnt = 2;
                2: cnt = $urandom_range(3, 20);
                3: cnt = 127;
                4: cnt = 1;
                5: cnt = $urandom_range(MAX_FRAMES + 1, 126);
                6: cnt = $urandom_range(3, MAX_FRAMES);
                default: cnt = 0;
            endcase
            wait_idle();
            set_frame_count(CNT_W'(cnt));
            load_table(gen_n, $urandom_range(0, 4) == 0);
            mix = $urandom_range(40, 110);
            repeat (mix) begin
                if ($urandom_range(0, 9) < 8) begin
                    queue_query(pick_query_time());
                end else begin
                    // Rewrites go mostly to slots outside the count or keep the slot's
                    // time; now and then one lands with a random time and breaks order.
                    slot = $urandom_range(0, MAX_FRAMES - 1);
                    if (gen_n < MAX_FRAMES && $urandom_range(0, 1) != 0) begin
                        slot = $urandom_range(gen_n, MAX_FRAMES - 1);
                    end
                    if (slot < gen_n && $urandom_range(0, 3) != 0) t = gen_time[slot];
                    else t = $urandom();
                    queue_write(6'(slot), t, rand_coord(), rand_coord(), rand_coord());
                end
            end
            phase++;
        end

        // Results that never arrive keep this wait open until the timeout fires.
        wait_idle();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== keyframe_position_interpolator.f =====
+incdir+rtl/core
rtl/core/kfpi_pkg.sv
rtl/core/kfpi_table.sv
rtl/core/kfpi_div.sv
rtl/core/kfpi_blend.sv
rtl/core/keyframe_position_interpolator.sv
rtl/core/kfpi_checker.sv
verif/keyframe_position_interpolator_tb.sv
